// ----- src/kmq_pkg.sv -----
// ----------------------------------------------------------------------------
// kmq_pkg: shared types and codes of the keyed message queue
// Beat structs for both channels, command and status codes, default sizes.
// ----------------------------------------------------------------------------
package kmq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int TARGET_BITS_DEF  = 16;

  localparam int CMD_W    = 2;
  localparam int TGT_IN_W = 16;
  localparam int PAY_W    = 32;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [TGT_IN_W-1:0] dest_id;
    logic [PAY_W-1:0]    payload;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PAY_W-1:0]  payload_out;
    logic [CNT_W-1:0]  count_out;
  } out_beat_t;

endpackage

// ----- src/kmq_store.sv -----
// ----------------------------------------------------------------------------
// kmq_store: entry memory of the keyed message queue
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kmq_store #(
  parameter int DEPTH = kmq_pkg::QUEUE_DEPTH_DEF,
  parameter int WIDTH = kmq_pkg::TARGET_BITS_DEF + kmq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/kmq_seq.sv -----
// ----------------------------------------------------------------------------
// kmq_seq: command sequencer of the keyed message queue
// Scans the entry memory one entry per cycle with a shared key compare and
// hit counter, and closes the gap after a take by copying entries down.
// ----------------------------------------------------------------------------
module kmq_seq #(
  parameter int QUEUE_DEPTH  = kmq_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = kmq_pkg::PAYLOAD_BITS_DEF,
  parameter int TARGET_BITS  = kmq_pkg::TARGET_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  kmq_pkg::in_beat_t                    in_beat,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output kmq_pkg::out_beat_t                   res_beat,
  output logic                                 mem_wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0]       mem_wr_addr,
  output logic [TARGET_BITS+PAYLOAD_BITS-1:0]  mem_wr_data,
  output logic                                 mem_rd_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0]       mem_rd_addr,
  input  logic [TARGET_BITS+PAYLOAD_BITS-1:0]  mem_rd_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  function automatic logic [kmq_pkg::CNT_W-1:0] cnt_fit(input logic [OCC_W-1:0] v);
    logic [OCC_W+kmq_pkg::CNT_W-1:0] t;
    t = {{kmq_pkg::CNT_W{1'b0}}, v};
    return t[kmq_pkg::CNT_W-1:0];
  endfunction

  function automatic logic [kmq_pkg::PAY_W-1:0] pay_fit(input logic [PAYLOAD_BITS-1:0] v);
    logic [PAYLOAD_BITS+kmq_pkg::PAY_W-1:0] t;
    t = {{kmq_pkg::PAY_W{1'b0}}, v};
    return t[kmq_pkg::PAY_W-1:0];
  endfunction

  state_t                       state_r, state_nxt;
  logic [kmq_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [TARGET_BITS-1:0]       key_r, key_nxt;
  logic [OCC_W-1:0]             occ_r, occ_nxt;
  logic [OCC_W-1:0]             idx_r, idx_nxt;
  logic [OCC_W-1:0]             hits_r, hits_nxt;
  logic                         pend_r, pend_nxt;
  logic [IDX_W-1:0]             wr_ptr_r, wr_ptr_nxt;
  kmq_pkg::out_beat_t           res_r, res_nxt;

  logic [kmq_pkg::TGT_IN_W+TARGET_BITS-1:0] key_ext;
  logic [kmq_pkg::PAY_W+PAYLOAD_BITS-1:0]   data_ext;
  logic [TARGET_BITS-1:0]                   key_in;
  logic [PAYLOAD_BITS-1:0]                  data_in;
  logic [TARGET_BITS-1:0]                   rd_target;
  logic [PAYLOAD_BITS-1:0]                  rd_payload;
  logic [OCC_W-1:0]                         idx_prev;
  logic                                     issue;
  logic                                     hit;

  // Narrow or zero-extend the input fields to the stored widths
  assign key_ext  = {{TARGET_BITS{1'b0}}, in_beat.dest_id};
  assign data_ext = {{PAYLOAD_BITS{1'b0}}, in_beat.payload};
  assign key_in   = key_ext[TARGET_BITS-1:0];
  assign data_in  = data_ext[PAYLOAD_BITS-1:0];

  assign rd_target  = mem_rd_data[TARGET_BITS+PAYLOAD_BITS-1:PAYLOAD_BITS];
  assign rd_payload = mem_rd_data[PAYLOAD_BITS-1:0];
  assign idx_prev   = idx_r - 1'b1;

  // Shared key compare on the entry read last cycle
  assign hit   = pend_r && (rd_target == key_r);
  assign issue = ((state_r == ST_SCAN) || (state_r == ST_SHIFT)) && (idx_r < occ_r);

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_FIN);
  assign res_beat  = res_r;

  assign mem_rd_en   = issue;
  assign mem_rd_addr = idx_r[IDX_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    occ_nxt     = occ_r;
    idx_nxt     = idx_r;
    hits_nxt    = hits_r;
    wr_ptr_nxt  = wr_ptr_r;
    res_nxt     = res_r;
    pend_nxt    = issue;
    mem_wr_en   = 1'b0;
    mem_wr_addr = occ_r[IDX_W-1:0];
    mem_wr_data = {key_in, data_in};

    if (issue) begin
      idx_nxt = idx_r + 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = in_beat.command;
          key_nxt  = key_in;
          idx_nxt  = '0;
          hits_nxt = '0;
          res_nxt.status      = kmq_pkg::STAT_OK;
          res_nxt.payload_out = '0;
          res_nxt.count_out   = cnt_fit(occ_r);
          unique case (in_beat.command) inside
            kmq_pkg::CMD_PUSH: begin
              if (occ_r == DEPTH_OCC) begin
                res_nxt.status = kmq_pkg::STAT_FULL;
              end else begin
                mem_wr_en         = 1'b1;
                occ_nxt           = occ_r + 1'b1;
                res_nxt.count_out = cnt_fit(occ_r + 1'b1);
              end
              state_nxt = ST_FIN;
            end
            kmq_pkg::CMD_TAKE, kmq_pkg::CMD_COUNT: begin
              state_nxt = ST_SCAN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit && (cmd_r == kmq_pkg::CMD_TAKE)) begin
          // The read issued this cycle is the entry right after the match
          res_nxt.status      = kmq_pkg::STAT_OK;
          res_nxt.payload_out = pay_fit(rd_payload);
          res_nxt.count_out   = '0;
          wr_ptr_nxt          = idx_prev[IDX_W-1:0];
          state_nxt           = ST_SHIFT;
        end else if (hit) begin
          hits_nxt = hits_r + 1'b1;
        end else if (!pend_r && !issue) begin
          res_nxt.payload_out = '0;
          if (cmd_r == kmq_pkg::CMD_TAKE) begin
            res_nxt.status    = kmq_pkg::STAT_NONE;
            res_nxt.count_out = '0;
          end else begin
            res_nxt.status    = kmq_pkg::STAT_OK;
            res_nxt.count_out = cnt_fit(hits_r);
          end
          state_nxt = ST_FIN;
        end
      end
      ST_SHIFT: begin
        // Copy each later entry down by one slot
        if (pend_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = wr_ptr_r;
          mem_wr_data = mem_rd_data;
          wr_ptr_nxt  = wr_ptr_r + 1'b1;
        end else if (!issue) begin
          occ_nxt   = occ_r - 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      occ_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    idx_r    <= idx_nxt;
    hits_r   <= hits_nxt;
    wr_ptr_r <= wr_ptr_nxt;
    res_r    <= res_nxt;
  end

endmodule

// ----- src/keyed_message_queue.sv -----
// Push and unknown commands answer without a scan; take and count scan the queue first,
//   so their result comes later the more entries the queue holds.
// Throughput: one command at a time; the next input beat is taken only once the result
//   has gone to the output register, so a command holds the block until then. The scan
//   reads one entry per cycle and a take copies the later entries down at the same pace.
// Reset: synchronous, active low; empties the queue. Entry contents are not cleared.
// ----------------------------------------------------------------------------
// keyed_message_queue: bounded message queue with keyed extraction
// Keeps messages in arrival order. Push appends, take removes the oldest
// message for a target and closes the gap, count returns matches per target.
// ----------------------------------------------------------------------------
module keyed_message_queue #(
  parameter int QUEUE_DEPTH  = kmq_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = kmq_pkg::PAYLOAD_BITS_DEF,
  parameter int TARGET_BITS  = kmq_pkg::TARGET_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kmq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kmq_pkg::out_beat_t out_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int ENT_W = TARGET_BITS + PAYLOAD_BITS;

  logic               seq_ready;
  logic               res_valid;
  logic               res_ready;
  kmq_pkg::out_beat_t res_beat;

  logic               mem_wr_en;
  logic [IDX_W-1:0]   mem_wr_addr;
  logic [ENT_W-1:0]   mem_wr_data;
  logic               mem_rd_en;
  logic [IDX_W-1:0]   mem_rd_addr;
  logic [ENT_W-1:0]   mem_rd_data;

  logic               out_valid_r;
  kmq_pkg::out_beat_t out_data_r;

  // Stall the input while the sequencer works on a command
  assign in_stall = !seq_ready;

  // The output register takes a new beat when empty or being drained
  assign res_ready = !out_valid_r || !out_stall;

  kmq_seq #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .TARGET_BITS  (TARGET_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (seq_ready),
    .in_beat     (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_beat    (res_beat),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // Entries are stored as {target, payload}, slot 0 oldest
  kmq_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENT_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register: hold the beat while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the keyed message queue
// A short scripted run covers the empty and full queue, extreme ids and
// payloads and the spare command. Then random traffic in fill, drain and even
// mixes runs with idle and stall on both channels. Every reply beat is checked
// against a hand-typed reply or one from a shadow copy of the queue kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          DEPTH        = kmq_pkg::QUEUE_DEPTH_DEF;
  localparam int          CNT_W        = kmq_pkg::CNT_W;
  localparam int          ID_W         = kmq_pkg::TGT_IN_W;
  localparam int          RANDOM_ITEMS = 1150;
  localparam int          QUIET_LIMIT  = 4000;  // cycles with no beat on either side
  localparam int          DRAIN_CYCLES = 40;    // longest scan plus copy-down, with margin
  // unused code, must answer like a no-op
  localparam logic [kmq_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  // One scripted beat; when 'typed' is set, 'want' is the reply read off by hand.
  typedef struct {
    kmq_pkg::in_beat_t  beat;
    bit                 typed;
    kmq_pkg::out_beat_t want;
  } script_row_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  kmq_pkg::in_beat_t  in_data   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  kmq_pkg::out_beat_t out_data;

  bit                  calm = 1'b0;  // high during the stretch with no idling
  int                  mismatch_count = 0;
  int unsigned         quiet_cycles = 0;
  script_row_t         script[$];
  kmq_pkg::out_beat_t  awaited_replies[$];
  logic [ID_W-1:0]     shadow_target[$];  // slot 0 holds the oldest message
  logic [kmq_pkg::PAY_W-1:0] shadow_payload[$];

  keyed_message_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // Apply one command to the shadow queue and return the reply it must give.
  function automatic kmq_pkg::out_beat_t predict_reply(input kmq_pkg::in_beat_t b);
    kmq_pkg::out_beat_t r;
    int                 hits;
    r    = '0;
    hits = 0;
    case (b.command)
      kmq_pkg::CMD_PUSH: begin
        if (shadow_target.size() >= DEPTH) begin
          // Full: drop the message, report the unchanged occupancy.
          r.status    = kmq_pkg::STAT_FULL;
          r.count_out = CNT_W'(shadow_target.size());
        end else begin
          shadow_target.push_back(b.dest_id);
          shadow_payload.push_back(b.payload);
          r.status    = kmq_pkg::STAT_OK;
          r.count_out = CNT_W'(shadow_target.size());
        end
      end
      kmq_pkg::CMD_TAKE: begin
        // Remove the oldest match and close the gap; no match leaves all alone.
        r.status = kmq_pkg::STAT_NONE;
        for (int i = 0; i < shadow_target.size(); i++) begin
          if (shadow_target[i] == b.dest_id) begin
            r.status      = kmq_pkg::STAT_OK;
            r.payload_out = shadow_payload[i];
            shadow_target.delete(i);
            shadow_payload.delete(i);
            break;
          end
        end
      end
      kmq_pkg::CMD_COUNT: begin
        foreach (shadow_target[i]) begin
          if (shadow_target[i] == b.dest_id) hits++;
        end
        r.status    = kmq_pkg::STAT_OK;
        r.count_out = CNT_W'(hits);
      end
      default: begin
        // Spare command: nothing changes, occupancy comes back.
        r.status    = kmq_pkg::STAT_OK;
        r.count_out = CNT_W'(shadow_target.size());
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(input logic [kmq_pkg::CMD_W-1:0] cmd,
                                  input logic [ID_W-1:0] tgt,
                                  input logic [kmq_pkg::PAY_W-1:0] pay, input bit typed,
                                  input logic [kmq_pkg::STAT_W-1:0] st,
                                  input logic [kmq_pkg::PAY_W-1:0] po,
                                  input logic [CNT_W-1:0] cnt);
    script_row_t row;
    row.beat  = '{command: cmd, dest_id: tgt, payload: pay};
    row.typed = typed;
    row.want  = '{status: st, payload_out: po, count_out: cnt};
    script.push_back(row);
  endfunction

  // Scripted opening: empty queue, extremes, fill to the brim, overflow,
  // extraction of the extremes, a miss and the spare command.
  function automatic void build_script();
    add_row(kmq_pkg::CMD_TAKE, 16'h0000, 32'h0000_0000, 1, kmq_pkg::STAT_NONE, '0, 5'd0);
    add_row(kmq_pkg::CMD_COUNT, 16'h0000, 32'h0000_0000, 1, kmq_pkg::STAT_OK, '0, 5'd0);
    add_row(CMD_SPARE, 16'hFFFF, 32'hDEAD_BEEF, 1, kmq_pkg::STAT_OK, '0, 5'd0);
    add_row(kmq_pkg::CMD_PUSH, 16'h0000, 32'h0000_0000, 1, kmq_pkg::STAT_OK, '0, 5'd1);
    add_row(kmq_pkg::CMD_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 1, kmq_pkg::STAT_OK, '0, 5'd2);
    // Fill the remaining slots with distinct ids; replies come from the shadow queue.
    for (int k = 0; k < DEPTH - 2; k++) begin
      add_row(kmq_pkg::CMD_PUSH, 16'hC000 + 16'(k), {16'hA5C3, 16'(k)}, 0,
              kmq_pkg::STAT_OK, '0, '0);
    end
    add_row(kmq_pkg::CMD_PUSH, 16'h4321, 32'h55AA_55AA, 1, kmq_pkg::STAT_FULL, '0,
            5'(DEPTH));
    add_row(kmq_pkg::CMD_COUNT, 16'hFFFF, 32'h0000_0000, 1, kmq_pkg::STAT_OK, '0, 5'd1);
    add_row(kmq_pkg::CMD_TAKE, 16'hFFFF, 32'h0F0F_0F0F, 1, kmq_pkg::STAT_OK,
            32'hFFFF_FFFF, 5'd0);
    add_row(kmq_pkg::CMD_TAKE, 16'h1234, 32'h0000_0000, 1, kmq_pkg::STAT_NONE, '0, 5'd0);
    add_row(CMD_SPARE, 16'h0000, 32'h0000_0000, 1, kmq_pkg::STAT_OK, '0, 5'(DEPTH - 1));
    add_row(kmq_pkg::CMD_TAKE, 16'h0000, 32'hFFFF_FFFF, 1, kmq_pkg::STAT_OK,
            32'h0000_0000, 5'd0);
  endfunction

  // Pick an id: a small pool so ids collide, a queued id so takes hit, or any id.
  function automatic logic [ID_W-1:0] pick_target();
    int roll;
    roll = $urandom_range(9);
    if (roll < 4) begin
      case (roll)
        0:       return 16'h0000;
        1:       return 16'hFFFF;
        2:       return 16'h00FF;
        default: return 16'hFF00;
      endcase
    end
    if (roll < 8 && shadow_target.size() != 0) begin
      return shadow_target[$urandom_range(shadow_target.size() - 1)];
    end
    return ID_W'($urandom);
  endfunction

  // Build a random command, weighted by the current mix so the queue
  // swings between empty and full.
  function automatic kmq_pkg::in_beat_t random_beat(input mix_t mix);
    kmq_pkg::in_beat_t b;
    int                roll;
    int                push_cut;
    int                take_cut;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  begin push_cut = 65; take_cut = 85; end
      MIX_DRAIN: begin push_cut = 25; take_cut = 75; end
      default:   begin push_cut = 40; take_cut = 70; end
    endcase
    if (roll < push_cut)      b.command = kmq_pkg::CMD_PUSH;
    else if (roll < take_cut) b.command = kmq_pkg::CMD_TAKE;
    else if (roll < 97)       b.command = kmq_pkg::CMD_COUNT;
    else                      b.command = CMD_SPARE;
    b.dest_id = pick_target();
    b.payload = $urandom;
    return b;
  endfunction

  // Offer one beat and return at the edge that accepts it. Idle first at
  // random; hold the payload steady while stalled.
  task automatic send_beat(input kmq_pkg::in_beat_t b);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Receiver: stall at random, never during the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 11);
  end

  // Check each accepted reply against the oldest one awaited.
  always @(posedge clk) begin : reply_check
    kmq_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("reply with nothing awaited", out_data.payload_out, '0);
      end else begin
        want = awaited_replies.pop_front();
        if (out_data.status !== want.status) begin
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        end
        if (out_data.payload_out !== want.payload_out) begin
          report_mismatch("payload_out", out_data.payload_out, want.payload_out);
        end
        if (out_data.count_out !== want.count_out) begin
          report_mismatch("count_out", 32'(out_data.count_out), 32'(want.count_out));
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    kmq_pkg::in_beat_t  beat;
    kmq_pkg::out_beat_t reply;
    mix_t               mix;
    mix = MIX_EVEN;
    build_script();

    // Hold reset, then release it once for the whole run.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scripted part: typed replies where known by hand, the shadow queue otherwise.
    // Advance the shadow queue on every row so the random part starts in step.
    foreach (script[r]) begin
      send_beat(script[r].beat);
      reply = predict_reply(script[r].beat);
      awaited_replies.push_back(script[r].typed ? script[r].want : reply);
    end

    // Random part: switch the mix every 50 beats; drop all idling for a while.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) mix = mix_t'($urandom_range(2));
      calm <= (n >= 500 && n < 700);
      beat = random_beat(mix);
      send_beat(beat);
      awaited_replies.push_back(predict_reply(beat));
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // Wait for every awaited reply, then a little longer to catch strays.
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
